FILE: src/srbh_pkg.sv
package srbh_pkg;

   // sign of an orientation test or of a difference
   typedef enum logic [1:0] {
      SGN_ZERO = 2'b00,
      SGN_POS  = 2'b01,
      SGN_NEG  = 2'b10
   } sign_type;

   // orientation signs that one edge test needs:
   // edge line against the segment end points, segment line against the edge corners
   typedef struct packed {
      sign_type edge_s;
      sign_type edge_e;
      sign_type seg_s;
      sign_type seg_e;
   } srbh_orient_type;

   typedef struct packed {
      logic meet;
      logic overlap;
   } srbh_edge_res_type;

   localparam int          EDGES       = 4;
   localparam logic [2:0]  HIT_OVERLAP = 3'd4;
   localparam int          RSP_BYTES   = 1;

   function automatic sign_type sign_mul(input sign_type a, input sign_type b);
      sign_type r;
      priority if (a == SGN_ZERO || b == SGN_ZERO) begin
         r = SGN_ZERO;
      end else if (a == b) begin
         r = SGN_POS;
      end else begin
         r = SGN_NEG;
      end
      return r;
   endfunction

   function automatic sign_type sign_neg(input sign_type a);
      sign_type r;
      unique case (a)
         SGN_POS: r = SGN_NEG;
         SGN_NEG: r = SGN_POS;
         default: r = SGN_ZERO;
      endcase
      return r;
   endfunction

endpackage

FILE: src/srbh_edge_test.sv
module srbh_edge_test
   import srbh_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  srbh_orient_type                orient,
   input  logic signed [COORD_BITS-1:0]   edge_x_lo,
   input  logic signed [COORD_BITS-1:0]   edge_x_hi,
   input  logic signed [COORD_BITS-1:0]   edge_y_lo,
   input  logic signed [COORD_BITS-1:0]   edge_y_hi,
   input  logic signed [COORD_BITS-1:0]   seg_x_lo,
   input  logic signed [COORD_BITS-1:0]   seg_x_hi,
   input  logic signed [COORD_BITS-1:0]   seg_y_lo,
   input  logic signed [COORD_BITS-1:0]   seg_y_hi,
   output srbh_edge_res_type              result
);

   logic                          all_col;
   logic signed [COORD_BITS-1:0]  ov_x_lo;
   logic signed [COORD_BITS-1:0]  ov_x_hi;
   logic signed [COORD_BITS-1:0]  ov_y_lo;
   logic signed [COORD_BITS-1:0]  ov_y_hi;
   logic                          touch;
   logic                          meet;
   logic                          overlap;

   assign all_col = (orient.edge_s == SGN_ZERO) && (orient.edge_e == SGN_ZERO) &&
                    (orient.seg_s == SGN_ZERO) && (orient.seg_e == SGN_ZERO);

   // intersection of the two closed bounding boxes
   assign ov_x_lo = (edge_x_lo > seg_x_lo) ? edge_x_lo : seg_x_lo;
   assign ov_x_hi = (edge_x_hi < seg_x_hi) ? edge_x_hi : seg_x_hi;
   assign ov_y_lo = (edge_y_lo > seg_y_lo) ? edge_y_lo : seg_y_lo;
   assign ov_y_hi = (edge_y_hi < seg_y_hi) ? edge_y_hi : seg_y_hi;

   assign touch   = all_col && (ov_x_lo <= ov_x_hi) && (ov_y_lo <= ov_y_hi);
   assign overlap = all_col && ((ov_x_lo < ov_x_hi) || (ov_y_lo < ov_y_hi));

   always_comb begin
      priority if (orient.edge_s == orient.edge_e) begin
         meet = (orient.edge_s == SGN_ZERO) && touch;
      end else if (orient.seg_s == orient.seg_e) begin
         meet = (orient.seg_s == SGN_ZERO) && touch;
      end else begin
         meet = 1'b1;
      end
   end

   assign result = '{meet: meet, overlap: overlap};

endmodule

FILE: src/segment_rect_boundary_hits.sv
// Counts the distinct points that a line segment shares with the boundary of an
// axis-aligned rectangle. One request word carries the two rectangle corners and
// the segment end points; one response word gives hit_count (0 to 4) and
// overlap_flag, which is set, with hit_count 4, when the segment runs along an edge
// for a positive length. A word is taken every cycle unless rsp_tready holds the
// response back; each word passes through an input register, one pass of eight
// exact (COORD_BITS+1)-bit orientation multipliers with compare and count logic,
// and the response register. While rsp_tready stays low the two registers fill
// and req_tready drops with two words held. Coordinates are two's complement,
// COORD_BITS wide.
module segment_rect_boundary_hits
   import srbh_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // rect_x_first, rect_y_first, rect_x_second, rect_y_second,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y; zero padded to bytes
   input  logic [((8*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // hit_count [2:0], overlap_flag [3], zero padded
   output logic [RSP_BYTES*8-1:0]                 rsp_tdata
);

   localparam int CW     = COORD_BITS;
   localparam int DW     = COORD_BITS + 1;
   localparam int PW     = 2*COORD_BITS + 2;
   localparam int FIELDS = 8;

   // corner order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
   localparam int EDGE_START [EDGES] = '{0, 2, 0, 1};
   localparam int EDGE_END   [EDGES] = '{1, 3, 2, 3};

   function automatic sign_type cmp_sign(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
      sign_type r;
      priority if (a > b) begin
         r = SGN_POS;
      end else if (a == b) begin
         r = SGN_ZERO;
      end else begin
         r = SGN_NEG;
      end
      return r;
   endfunction

   // handshake
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic req_take;
   logic out_load;

   logic signed [CW-1:0] field_ff [FIELDS];

   logic signed [CW-1:0] x1, y1, x2, y2, sx, sy, ex, ey;
   logic signed [CW-1:0] rx_lo, rx_hi, ry_lo, ry_hi;
   logic signed [CW-1:0] sx_lo, sx_hi, sy_lo, sy_hi;
   logic signed [DW-1:0] seg_dx, seg_dy;
   sign_type             rect_sx, rect_sy;

   logic signed [CW-1:0] corner_x [EDGES];
   logic signed [CW-1:0] corner_y [EDGES];
   sign_type             corner_orient [EDGES];
   logic                 corner_on [EDGES];

   srbh_orient_type      edge_orient [EDGES];
   srbh_edge_res_type    edge_res [EDGES];
   logic signed [CW-1:0] edge_x_lo [EDGES];
   logic signed [CW-1:0] edge_x_hi [EDGES];
   logic signed [CW-1:0] edge_y_lo [EDGES];
   logic signed [CW-1:0] edge_y_hi [EDGES];
   logic [EDGES-1:0]     edge_end_on;

   logic [2:0] hits;
   logic [2:0] ends;
   logic [2:0] half;
   logic       any_overlap;
   logic [2:0] hit_count_in, hit_count_ff;
   logic       overlap_in, overlap_ff;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign out_load   = out_free && in_valid_ff;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int f = 0; f < FIELDS; f++) begin
            field_ff[f] <= req_tdata[f*CW +: CW];
         end
      end
      if (out_load) begin
         hit_count_ff <= hit_count_in;
         overlap_ff   <= overlap_in;
      end
   end

   assign x1 = field_ff[0];
   assign y1 = field_ff[1];
   assign x2 = field_ff[2];
   assign y2 = field_ff[3];
   assign sx = field_ff[4];
   assign sy = field_ff[5];
   assign ex = field_ff[6];
   assign ey = field_ff[7];

   assign rx_lo = (x1 < x2) ? x1 : x2;
   assign rx_hi = (x1 < x2) ? x2 : x1;
   assign ry_lo = (y1 < y2) ? y1 : y2;
   assign ry_hi = (y1 < y2) ? y2 : y1;
   assign sx_lo = (sx < ex) ? sx : ex;
   assign sx_hi = (sx < ex) ? ex : sx;
   assign sy_lo = (sy < ey) ? sy : ey;
   assign sy_hi = (sy < ey) ? ey : sy;

   assign seg_dx  = {ex[CW-1], ex} - {sx[CW-1], sx};
   assign seg_dy  = {ey[CW-1], ey} - {sy[CW-1], sy};
   assign rect_sx = cmp_sign(x2, x1);
   assign rect_sy = cmp_sign(y2, y1);

   assign corner_x[0] = x1;  assign corner_y[0] = y1;
   assign corner_x[1] = x2;  assign corner_y[1] = y1;
   assign corner_x[2] = x1;  assign corner_y[2] = y2;
   assign corner_x[3] = x2;  assign corner_y[3] = y2;

   // orientation of each corner against the segment line, and whether it lies on the segment
   for (genvar k = 0; k < EDGES; k++) begin : g_corner
      logic signed [DW-1:0] cdx, cdy;
      logic signed [PW-1:0] lhs, rhs;

      assign cdx = {corner_x[k][CW-1], corner_x[k]} - {sx[CW-1], sx};
      assign cdy = {corner_y[k][CW-1], corner_y[k]} - {sy[CW-1], sy};
      assign lhs = PW'(seg_dx) * PW'(cdy);
      assign rhs = PW'(seg_dy) * PW'(cdx);

      assign corner_orient[k] = (lhs > rhs) ? SGN_POS : ((lhs == rhs) ? SGN_ZERO : SGN_NEG);
      assign corner_on[k] = (lhs == rhs) &&
                            (sx_lo <= corner_x[k]) && (corner_x[k] <= sx_hi) &&
                            (sy_lo <= corner_y[k]) && (corner_y[k] <= sy_hi);
   end

   // axis-aligned edges: their orientation tests reduce to products of signs
   assign edge_orient[0].edge_s = sign_mul(rect_sx, cmp_sign(sy, y1));
   assign edge_orient[0].edge_e = sign_mul(rect_sx, cmp_sign(ey, y1));
   assign edge_orient[1].edge_s = sign_mul(rect_sx, cmp_sign(sy, y2));
   assign edge_orient[1].edge_e = sign_mul(rect_sx, cmp_sign(ey, y2));
   assign edge_orient[2].edge_s = sign_neg(sign_mul(rect_sy, cmp_sign(sx, x1)));
   assign edge_orient[2].edge_e = sign_neg(sign_mul(rect_sy, cmp_sign(ex, x1)));
   assign edge_orient[3].edge_s = sign_neg(sign_mul(rect_sy, cmp_sign(sx, x2)));
   assign edge_orient[3].edge_e = sign_neg(sign_mul(rect_sy, cmp_sign(ex, x2)));

   assign edge_x_lo[0] = rx_lo;  assign edge_x_hi[0] = rx_hi;
   assign edge_y_lo[0] = y1;     assign edge_y_hi[0] = y1;
   assign edge_x_lo[1] = rx_lo;  assign edge_x_hi[1] = rx_hi;
   assign edge_y_lo[1] = y2;     assign edge_y_hi[1] = y2;
   assign edge_x_lo[2] = x1;     assign edge_x_hi[2] = x1;
   assign edge_y_lo[2] = ry_lo;  assign edge_y_hi[2] = ry_hi;
   assign edge_x_lo[3] = x2;     assign edge_x_hi[3] = x2;
   assign edge_y_lo[3] = ry_lo;  assign edge_y_hi[3] = ry_hi;

   for (genvar i = 0; i < EDGES; i++) begin : g_edge
      assign edge_orient[i].seg_s = corner_orient[EDGE_START[i]];
      assign edge_orient[i].seg_e = corner_orient[EDGE_END[i]];
      assign edge_end_on[i]       = corner_on[EDGE_START[i]] || corner_on[EDGE_END[i]];

      srbh_edge_test #(
         .COORD_BITS (COORD_BITS)
      ) u_edge (
         .orient    (edge_orient[i]),
         .edge_x_lo (edge_x_lo[i]),
         .edge_x_hi (edge_x_hi[i]),
         .edge_y_lo (edge_y_lo[i]),
         .edge_y_hi (edge_y_hi[i]),
         .seg_x_lo  (sx_lo),
         .seg_x_hi  (sx_hi),
         .seg_y_lo  (sy_lo),
         .seg_y_hi  (sy_hi),
         .result    (edge_res[i])
      );
   end

   always_comb begin
      hits        = 3'd0;
      ends        = 3'd0;
      any_overlap = 1'b0;
      for (int i = 0; i < EDGES; i++) begin
         hits        = hits + 3'(edge_res[i].meet);
         ends        = ends + 3'(edge_end_on[i]);
         any_overlap = any_overlap | edge_res[i].overlap;
      end
   end

   // a corner on the segment is met by both of its edges: drop half of those
   assign half = {1'b0, ends[2:1]};

   always_comb begin
      priority if (any_overlap) begin
         hit_count_in = HIT_OVERLAP;
         overlap_in   = 1'b1;
      end else if (hits >= half) begin
         hit_count_in = hits - half;
         overlap_in   = 1'b0;
      end else begin
         hit_count_in = 3'd0;
         overlap_in   = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES*8-4){1'b0}}, overlap_ff, hit_count_ff};

   a_overlap_four: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && overlap_ff |-> hit_count_ff == HIT_OVERLAP)
      else $error("overlap flag without count of four");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> hit_count_ff <= HIT_OVERLAP)
      else $error("hit count above four");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> out_valid_ff)
      else $error("word lost between input and response register");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request stalled with room in the pipeline");

endmodule

FILE: dv/tb_segment_rect_boundary_hits.sv
module tb_segment_rect_boundary_hits;
   import srbh_pkg::*;

   localparam int COORD_BITS      = 16;
   localparam int REQ_W           = ((8*COORD_BITS+7)/8)*8;
   localparam int RANDOM_WORDS    = 1026;
   localparam int HOLD_AFTER      = 400;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES = 5000;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   // first field in the lowest bits
   typedef struct packed {
      coord_t seg_end_y;
      coord_t seg_end_x;
      coord_t seg_start_y;
      coord_t seg_start_x;
      coord_t rect_y_second;
      coord_t rect_x_second;
      coord_t rect_y_first;
      coord_t rect_x_first;
   } query_t;

   typedef struct packed {
      logic       overlap_flag;
      logic [2:0] hit_count;
   } hit_result_t;

   typedef struct {
      query_t      q;
      bit          typed;
      hit_result_t want;
   } dir_row_t;

   typedef struct {
      longint x;
      longint y;
   } point_t;

   typedef struct {
      point_t a;
      point_t b;
   } line_seg_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;

   hit_result_t        pending_hits [$];
   dir_row_t           dir_rows [$];
   int unsigned        words_sent = 0;
   int unsigned        words_checked = 0;
   int unsigned        overlap_words = 0;
   int unsigned        empty_words = 0;
   int unsigned        multi_words = 0;
   int unsigned        mismatches = 0;
   int unsigned        idle_cycles = 0;
   int unsigned        hold_left = 0;
   bit                 hold_done = 1'b0;
   int unsigned        stall_mode = 0;
   int unsigned        stall_left = 0;
   int unsigned        rx_cycle = 0;

   segment_rect_boundary_hits #(.COORD_BITS(COORD_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic point_t mk_point(longint x, longint y);
      point_t p;
      p.x = x;
      p.y = y;
      return p;
   endfunction

   function automatic longint min2(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint max2(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic sign_type turn(point_t p, point_t q, point_t r);
      longint lhs, rhs;
      lhs = (q.x - p.x) * (r.y - p.y);
      rhs = (q.y - p.y) * (r.x - p.x);
      if (lhs > rhs) return SGN_POS;
      if (lhs == rhs) return SGN_ZERO;
      return SGN_NEG;
   endfunction

   // collinear only when each lies on the other's line, so a point edge needs care
   function automatic bit on_one_line(line_seg_t p, line_seg_t q);
      return turn(p.a, p.b, q.a) == SGN_ZERO && turn(p.a, p.b, q.b) == SGN_ZERO &&
             turn(q.a, q.b, p.a) == SGN_ZERO && turn(q.a, q.b, p.b) == SGN_ZERO;
   endfunction

   function automatic bit shared_span(line_seg_t p, line_seg_t q, bit strict);
      longint xl, xh, yl, yh;
      if (!on_one_line(p, q)) return 1'b0;
      xl = max2(min2(p.a.x, p.b.x), min2(q.a.x, q.b.x));
      xh = min2(max2(p.a.x, p.b.x), max2(q.a.x, q.b.x));
      yl = max2(min2(p.a.y, p.b.y), min2(q.a.y, q.b.y));
      yh = min2(max2(p.a.y, p.b.y), max2(q.a.y, q.b.y));
      if (strict) return (xl < xh) || (yl < yh);
      return (xl <= xh) && (yl <= yh);
   endfunction

   function automatic bit touches(line_seg_t p, line_seg_t q);
      sign_type s1, s2, s3, s4;
      s1 = turn(p.a, p.b, q.a);
      s2 = turn(p.a, p.b, q.b);
      if (s1 == s2) return (s1 == SGN_ZERO) ? shared_span(p, q, 1'b0) : 1'b0;
      s3 = turn(q.a, q.b, p.a);
      s4 = turn(q.a, q.b, p.b);
      if (s3 == s4) return (s3 == SGN_ZERO) ? shared_span(p, q, 1'b0) : 1'b0;
      return 1'b1;
   endfunction

   function automatic bit point_on(line_seg_t q, point_t p);
      return turn(q.a, p, q.b) == SGN_ZERO &&
             min2(q.a.x, q.b.x) <= p.x && p.x <= max2(q.a.x, q.b.x) &&
             min2(q.a.y, q.b.y) <= p.y && p.y <= max2(q.a.y, q.b.y);
   endfunction

   function automatic hit_result_t boundary_hits(query_t c);
      point_t      c00, c10, c01, c11;
      line_seg_t   sg;
      line_seg_t   sides [EDGES];
      int unsigned corners_on, meets, overlaps, half;
      hit_result_t r;
      c00 = mk_point(c.rect_x_first,  c.rect_y_first);
      c10 = mk_point(c.rect_x_second, c.rect_y_first);
      c01 = mk_point(c.rect_x_first,  c.rect_y_second);
      c11 = mk_point(c.rect_x_second, c.rect_y_second);
      sg.a = mk_point(c.seg_start_x, c.seg_start_y);
      sg.b = mk_point(c.seg_end_x, c.seg_end_y);
      sides[0] = '{c00, c10};
      sides[1] = '{c01, c11};
      sides[2] = '{c00, c01};
      sides[3] = '{c10, c11};
      corners_on = 0;
      meets      = 0;
      overlaps   = 0;
      for (int i = 0; i < EDGES; i++) begin
         if (point_on(sg, sides[i].a) || point_on(sg, sides[i].b)) corners_on++;
         if (shared_span(sides[i], sg, 1'b1)) overlaps++;
         if (touches(sides[i], sg)) meets++;
      end
      if (overlaps != 0) begin
         r.hit_count    = HIT_OVERLAP;
         r.overlap_flag = 1'b1;
      end else begin
         // a corner on the segment was counted by both of its edges
         half           = corners_on / 2;
         r.hit_count    = (meets >= half) ? 3'(meets - half) : 3'd0;
         r.overlap_flag = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void add_row(int x1, int y1, int x2, int y2, int sx, int sy,
                                   int ex, int ey, bit typed, int hc, int ov);
      dir_row_t row;
      row.q.rect_x_first  = coord_t'(x1);
      row.q.rect_y_first  = coord_t'(y1);
      row.q.rect_x_second = coord_t'(x2);
      row.q.rect_y_second = coord_t'(y2);
      row.q.seg_start_x   = coord_t'(sx);
      row.q.seg_start_y   = coord_t'(sy);
      row.q.seg_end_x     = coord_t'(ex);
      row.q.seg_end_y     = coord_t'(ey);
      row.typed             = typed;
      row.want.hit_count    = 3'(hc);
      row.want.overlap_flag = 1'(ov);
      dir_rows.push_back(row);
   endfunction

   function automatic coord_t pick(int unsigned scale);
      coord_t v;
      case (scale)
         0: v = coord_t'($urandom);
         1: v = coord_t'($urandom_range(0, 12) - 6);
         2: v = coord_t'($urandom_range(0, 4000) - 2000);
         default: begin
            case ($urandom_range(0, 6))
               0: v = coord_t'(-32768);
               1: v = coord_t'(-32767);
               2: v = coord_t'(-1);
               3: v = coord_t'(0);
               4: v = coord_t'(1);
               5: v = coord_t'(32766);
               default: v = coord_t'(32767);
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic query_t random_query();
      query_t      q;
      int unsigned kind, scale;
      kind = $urandom_range(0, 9);
      case (kind)
         0:       scale = 0;
         1, 2:    scale = 1;
         3:       scale = 2;
         4:       scale = 3;
         default: scale = $urandom_range(1, 2);
      endcase
      q.rect_x_first  = pick(scale);
      q.rect_y_first  = pick(scale);
      q.rect_x_second = pick(scale);
      q.rect_y_second = pick(scale);
      q.seg_start_x   = pick(scale);
      q.seg_start_y   = pick(scale);
      q.seg_end_x     = pick(scale);
      q.seg_end_y     = pick(scale);
      case (kind)
         5, 6: begin
            // lay the segment on the line of one edge
            case ($urandom_range(0, 3))
               0: begin q.seg_start_y = q.rect_y_first;  q.seg_end_y = q.rect_y_first;  end
               1: begin q.seg_start_y = q.rect_y_second; q.seg_end_y = q.rect_y_second; end
               2: begin q.seg_start_x = q.rect_x_first;  q.seg_end_x = q.rect_x_first;  end
               default: begin q.seg_start_x = q.rect_x_second; q.seg_end_x = q.rect_x_second; end
            endcase
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               q.seg_start_x = $urandom_range(0, 1) ? q.rect_x_first : q.rect_x_second;
               q.seg_start_y = $urandom_range(0, 1) ? q.rect_y_first : q.rect_y_second;
            end
            if ($urandom_range(0, 1)) begin
               q.seg_end_x = $urandom_range(0, 1) ? q.rect_x_first : q.rect_x_second;
               q.seg_end_y = $urandom_range(0, 1) ? q.rect_y_first : q.rect_y_second;
            end
         end
         8: begin
            if ($urandom_range(0, 1)) q.rect_x_second = q.rect_x_first;
            else q.rect_y_second = q.rect_y_first;
         end
         9: begin
            case ($urandom_range(0, 2))
               0: begin
                  q.seg_start_x = $urandom_range(0, 1) ? q.rect_x_first : q.rect_x_second;
                  q.seg_start_y = $urandom_range(0, 1) ? q.rect_y_first : q.rect_y_second;
               end
               1: q.seg_start_x = $urandom_range(0, 1) ? q.rect_x_first : q.rect_x_second;
               default: ;
            endcase
            q.seg_end_x = q.seg_start_x;
            q.seg_end_y = q.seg_start_y;
         end
         default: ;
      endcase
      return q;
   endfunction

   int unsigned burst_left = 0;

   // offer a word and hold it until the block takes it
   task automatic send_word(query_t q, bit typed, hit_result_t want);
      req_tdata  <= REQ_W'(q);
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      pending_hits.push_back(typed ? want : boundary_hits(q));
      words_sent++;
      @(posedge clock);
   endtask

   task automatic pace(bit last);
      if (burst_left == 0) burst_left = $urandom_range(1, 30);
      burst_left--;
      if (last || burst_left == 0) req_tvalid <= 1'b0;
      if (!last && burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin
      query_t q;
      add_row(0, 0, 10, 10,  20, 20, 30, 30,  1, 0, 0);
      add_row(0, 0, 10, 10,  -5, 5, 15, 5,    1, 2, 0);
      add_row(0, 0, 10, 10,  5, -5, 5, 15,    1, 2, 0);
      add_row(0, 0, 10, 10,  2, 0, 8, 0,      1, 4, 1);
      add_row(0, 0, 10, 10,  -3, 10, 13, 10,  1, 4, 1);
      add_row(0, 0, 10, 10,  3, 3, 7, 7,      1, 0, 0);
      add_row(0, 0, 10, 10,  5, 5, 5, 5,      1, 0, 0);
      add_row(0, 0, 10, 10,  10, 0, 20, 0,    0, 0, 0);
      add_row(0, 0, 10, 10,  -5, 5, 5, -5,    0, 0, 0);
      add_row(0, 0, 10, 10,  0, 0, 10, 10,    0, 0, 0);
      add_row(0, 0, 10, 10,  10, 10, 10, 10,  0, 0, 0);
      add_row(0, 0, 10, 10,  5, 0, 5, 0,      0, 0, 0);
      add_row(0, 0, 10, 10,  -1, 9, 1, 11,    0, 0, 0);
      add_row(10, 10, 0, 0,  -5, 5, 15, 5,    0, 0, 0);
      add_row(3, 3, 3, 3,    0, 0, 6, 6,      0, 0, 0);
      add_row(3, 4, 3, 4,    0, 0, 6, 6,      0, 0, 0);
      add_row(0, 0, 0, 10,   0, 2, 0, 8,      0, 0, 0);
      add_row(0, 0, 0, 10,   -5, 5, 5, 5,     0, 0, 0);
      add_row(0, 0, 0, 0,    0, 0, 0, 0,      0, 0, 0);
      add_row(-1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0);
      add_row(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 0, 0, 0);
      add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, 32767, 1, 4, 1);
      add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 0);
      add_row(32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want);
         pace(1'b0);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         q = random_query();
         send_word(q, 1'b0, '0);
         pace(n == RANDOM_WORDS - 1);
      end

      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d queries (%0d typed rows): %0d edge overlaps, %0d with no point,",
               words_checked, dir_rows.size(), overlap_words, empty_words);
      $display("%0d with two or more points, bursty input and one %0d-cycle output hold-off",
               multi_words, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("tb_segment_rect_boundary_hits: done, clean");
      end else begin
         $display("tb_segment_rect_boundary_hits: done, errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      rx_cycle++;
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && words_sent >= HOLD_AFTER) begin
         // hold off long enough for the block to fill and stall its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (rx_cycle % 4) != 3;
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- checking

   // sample on the falling edge, away from the driving rising edge
   always @(negedge clock) begin
      hit_result_t want, got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit_count    = rsp_tdata[2:0];
            got.overlap_flag = rsp_tdata[3];
            words_checked++;
            if (got.overlap_flag) overlap_words++;
            else if (got.hit_count == 0) empty_words++;
            else if (got.hit_count > 1) multi_words++;
            if (pending_hits.size() == 0) begin
               mismatches++;
               $display("%0t: response word with none expected, got hit_count %0d overlap %0d",
                        $time, got.hit_count, got.overlap_flag);
            end else begin
               want = pending_hits.pop_front();
               if (got.hit_count !== want.hit_count) begin
                  mismatches++;
                  $display("%0t: hit_count expected %0d, got %0d",
                           $time, want.hit_count, got.hit_count);
               end
               if (got.overlap_flag !== want.overlap_flag) begin
                  mismatches++;
                  $display("%0t: overlap_flag expected %0d, got %0d",
                           $time, want.overlap_flag, got.overlap_flag);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
                     $time, idle_cycles, pending_hits.size());
            $display("tb_segment_rect_boundary_hits: done, errors");
            $finish;
         end
      end
   end

endmodule

FILE: segment_rect_boundary_hits.f
src/srbh_pkg.sv
src/srbh_edge_test.sv
src/segment_rect_boundary_hits.sv
dv/tb_segment_rect_boundary_hits.sv
